@@ hdl/mhpq_pkg.sv @@
// Shared types and constants for the binary min-heap priority queue.
// Depends on nothing; the top level imports it.

package mhpq_pkg;

    localparam int CAPACITY = 1024;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CHILD_W  = IDX_W + 2;
    localparam int VAL_W    = 32;

    // Request kinds.
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_POP_RD,
        S_POP_LD,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } t_state;

endpackage

@@ hdl/mhpq_ram.sv @@
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.

module mhpq_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WIDTH-1:0]  o_rdata_a,
    output logic [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

@@ hdl/min_heap_priority_queue.sv @@
// Top level of the binary min-heap priority queue: sequencer and shared compare.
// Depends on mhpq_pkg and mhpq_ram.
//
//  channel   | ports                                        | handshake
//  ----------+----------------------------------------------+-------------------------
//  request   | i_kind, i_value                              | start high, busy low
//  result    | o_popped_value, o_status, o_entry_count      | o_valid, one-cycle strobe
//
// A push climbs through S_UP_RD and S_UP_CMP once per level it rises and stops at the root
// or below a parent no larger than it. A pop reads the root and the last entry (S_POP_RD,
// S_POP_LD), then sinks through S_DN_RD and S_DN_CMP per level. Refused requests go to S_DONE.
// Reset is synchronous and empties the heap at once; the store itself is not cleared.
// The result is shown for one cycle and the receiver cannot stall it.

module min_heap_priority_queue
    import mhpq_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_kind,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_valid,
    output logic signed [VAL_W-1:0] o_popped_value,
    output logic [1:0]              o_status,
    output logic [CNT_W-1:0]        o_entry_count
);

    t_state                   r_state, n_state;
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic signed [VAL_W-1:0]  r_val, n_val;
    logic signed [VAL_W-1:0]  r_res, n_res;
    logic [1:0]               r_status, n_status;

    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic [VAL_W-1:0]         ram_wdata;
    logic [IDX_W-1:0]         ram_raddr_a;
    logic [IDX_W-1:0]         ram_raddr_b;
    logic [VAL_W-1:0]         ram_rdata_a;
    logic [VAL_W-1:0]         ram_rdata_b;

    logic [IDX_W-1:0]         parent_idx;
    logic [CHILD_W-1:0]       left_idx;
    logic [CHILD_W-1:0]       right_idx;
    logic [CHILD_W-1:0]       cnt_ext;
    logic signed [VAL_W-1:0]  rd_a;
    logic signed [VAL_W-1:0]  rd_b;
    logic                     left_less;
    logic                     right_less;
    logic signed [VAL_W-1:0]  best_val;

    mhpq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VAL_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    assign parent_idx = (r_idx - IDX_W'(1)) >> 1;
    assign left_idx   = CHILD_W'({r_idx, 1'b1});
    assign right_idx  = left_idx + CHILD_W'(1);
    assign cnt_ext    = CHILD_W'(r_cnt);
    assign rd_a       = $signed(ram_rdata_a);
    assign rd_b       = $signed(ram_rdata_b);

    // The shared comparator: the left child is checked against the sinking value,
    // then the right child against whichever of those two is smaller.
    assign left_less  = rd_a < r_val;
    assign best_val   = left_less ? rd_a : r_val;
    assign right_less = (right_idx < cnt_ext) && (rd_b < best_val);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_idx    <= n_idx;
        r_val    <= n_val;
        r_res    <= n_res;
        r_status <= n_status;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_val       = r_val;
        n_res       = r_res;
        n_status    = r_status;
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = r_val;
        ram_raddr_a = parent_idx;
        ram_raddr_b = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_res    = '0;
                    n_status = ST_OK;
                    if (i_kind == KIND_PUSH) begin
                        if (r_cnt == CNT_W'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_val   = i_value;
                            n_idx   = r_cnt[IDX_W-1:0];
                            n_cnt   = r_cnt + CNT_W'(1);
                            n_state = S_UP_RD;
                        end
                    end else begin
                        if (r_cnt == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_cnt   = r_cnt - CNT_W'(1);
                            n_state = S_POP_RD;
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (r_idx == '0) begin
                    ram_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    ram_raddr_a = parent_idx;
                    n_state     = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                ram_we = 1'b1;
                if (r_val < rd_a) begin
                    // Parent moves down into the hole; the hole climbs one level.
                    ram_wdata = ram_rdata_a;
                    n_idx     = parent_idx;
                    n_state   = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_POP_RD: begin
                // The count is already decremented, so it indexes the last entry.
                ram_raddr_a = '0;
                ram_raddr_b = r_cnt[IDX_W-1:0];
                n_state     = S_POP_LD;
            end
            S_POP_LD: begin
                n_res = rd_a;
                n_val = rd_b;
                n_idx = '0;
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_DN_RD;
                end
            end
            S_DN_RD: begin
                if (left_idx >= cnt_ext) begin
                    ram_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    ram_raddr_a = left_idx[IDX_W-1:0];
                    ram_raddr_b = right_idx[IDX_W-1:0];
                    n_state     = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                ram_we = 1'b1;
                if (right_less) begin
                    ram_wdata = ram_rdata_b;
                    n_idx     = right_idx[IDX_W-1:0];
                    n_state   = S_DN_RD;
                end else if (left_less) begin
                    ram_wdata = ram_rdata_a;
                    n_idx     = left_idx[IDX_W-1:0];
                    n_state   = S_DN_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = (r_state == S_DONE);
    assign o_popped_value = r_res;
    assign o_status       = r_status;
    assign o_entry_count  = r_cnt;

`ifndef NO_ASSERTIONS
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not make the block busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_entry_count == CNT_W'(CAPACITY)))
        else $error("full status with a heap that is not full");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |-> (o_entry_count == '0 && o_popped_value == '0))
        else $error("empty status with a non-empty heap or a non-zero value");
`endif

endmodule
